// ===== design/assert_macros.svh =====
// Assertion macros shared by the seed assignment RTL.
// Depends on nothing; included by modules that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
	else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
	else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

// ===== design/csa_pkg.sv =====
// Package for the capacity seed assignment block: sizes, types, sequencer states.
// Depends on nothing.
`default_nettype none
package csa_pkg;
	localparam int MaxVehicles = 16;
	localparam int VidxW = $clog2(MaxVehicles);
	localparam int CntW = $clog2(MaxVehicles + 1);
	localparam int CoordW = 16;
	localparam int CapW = 16;
	localparam int RadW = 50;
	localparam int DistW = 25;
	localparam int CostW = 28;
	localparam int CfgIdxW = 2;
	localparam int CfgDataW = 16;
	localparam logic [CfgIdxW-1:0] CfgDepotX = 2'd0;
	localparam logic [CfgIdxW-1:0] CfgDepotY = 2'd1;
	localparam logic [CfgIdxW-1:0] CfgCap = 2'd2;
	localparam logic [CfgIdxW-1:0] CfgCount = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE, ST_SQ, ST_ROOT, ST_NEXT, ST_DONE, ST_OUT
	} state_t;

	typedef struct packed {
		logic         valid;
		logic [VidxW-1:0] idx;
		logic signed [CoordW-1:0] sx;
		logic signed [CoordW-1:0] sy;
		logic [CapW-1:0]  cap;
	} cell_data_t;

	typedef struct packed {
		logic shift;
		logic load;
		logic [VidxW-1:0] load_idx;
		logic sub;
		logic [VidxW-1:0] sub_idx;
	} cell_ctrl_t;
endpackage
`default_nettype wire

// ===== design/csa_if.sv =====
// Valid/ready channel interfaces for input and result items.
// Depends on csa_pkg.
`default_nettype none
interface csa_in_if;
	import csa_pkg::*;
	logic valid;
	logic ready;
	logic mode;
	logic [VidxW-1:0] seed_index;
	logic signed [CoordW-1:0] pos_x;
	logic signed [CoordW-1:0] pos_y;
	logic [CapW-1:0] demand;
	modport source(output valid, mode, seed_index, pos_x, pos_y, demand, input ready);
	modport sink(input valid, mode, seed_index, pos_x, pos_y, demand, output ready);
endinterface

interface csa_out_if;
	import csa_pkg::*;
	logic valid;
	logic ready;
	logic assigned;
	logic [VidxW-1:0] vehicle;
	logic [CapW-1:0] capacity_left;
	modport source(output valid, assigned, vehicle, capacity_left, input ready);
	modport sink(input valid, assigned, vehicle, capacity_left, output ready);
endinterface
`default_nettype wire

// ===== design/csa_cell.sv =====
// One vehicle cell of the rotating ring: holds seed and remaining capacity.
// Depends on csa_pkg.
`default_nettype none
module csa_cell (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire csa_pkg::cell_ctrl_t ctrl,
	input  wire csa_pkg::cell_data_t prev,
	input  wire logic signed [csa_pkg::CoordW-1:0] new_x,
	input  wire logic signed [csa_pkg::CoordW-1:0] new_y,
	input  wire logic [csa_pkg::CapW-1:0] new_cap,
	input  wire logic [csa_pkg::CapW-1:0] sub_amt,
	input  wire logic [csa_pkg::VidxW-1:0] home,
	output csa_pkg::cell_data_t cur
);
	import csa_pkg::*;
	logic valid_q;
	logic [CapW-1:0] cap_q;
	logic [VidxW-1:0] idx_q;
	logic signed [CoordW-1:0] sx_q, sy_q;

	// the vehicle index travels with the cell contents round the ring
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			cap_q <= '0;
			idx_q <= home;
		end else if (ctrl.shift) begin
			valid_q <= prev.valid;
			cap_q <= prev.cap;
			idx_q <= prev.idx;
		end else if (ctrl.load && ctrl.load_idx == home) begin
			valid_q <= 1'b1;
			cap_q <= new_cap;
		end else if (ctrl.sub && ctrl.sub_idx == home) begin
			cap_q <= cap_q - sub_amt;
		end
	end

	// seeds are undefined until written: no reset
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			sx_q <= prev.sx;
			sy_q <= prev.sy;
		end else if (ctrl.load && ctrl.load_idx == home) begin
			sx_q <= new_x;
			sy_q <= new_y;
		end
	end

	always_comb begin
		cur.valid = valid_q;
		cur.idx = idx_q;
		cur.sx = sx_q;
		cur.sy = sy_q;
		cur.cap = cap_q;
	end
endmodule
`default_nettype wire

// ===== design/csa_isqrt.sv =====
// Bit-serial integer square root, two radicand bits per cycle.
// Depends on csa_pkg.
`default_nettype none
module csa_isqrt (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire logic [csa_pkg::RadW-1:0] rad,
	output logic busy,
	output logic [csa_pkg::DistW-1:0] root
);
	import csa_pkg::*;
	localparam int StepW = $clog2(DistW + 1);
	logic [RadW-1:0] rem_q;
	logic [DistW-1:0] root_q;
	logic [RadW-1:0] x_q;
	logic [StepW-1:0] step_q;
	logic [DistW+1:0] trial, remhi;
	logic [DistW+1:0] remtop;

	assign remtop = {rem_q[DistW-1:0], x_q[RadW-1 -: 2]};
	assign trial = {root_q, 2'b01};
	assign remhi = remtop - trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (start) begin
			step_q <= StepW'(DistW);
		end else if (step_q != '0) begin
			step_q <= step_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			root_q <= '0;
			x_q <= rad;
		end else if (step_q != '0) begin
			x_q <= {x_q[RadW-3:0], 2'b00};
			if (remtop >= trial) begin
				rem_q <= RadW'(remhi);
				root_q <= {root_q[DistW-2:0], 1'b1};
			end else begin
				rem_q <= RadW'(remtop);
				root_q <= {root_q[DistW-2:0], 1'b0};
			end
		end
	end

	assign busy = (step_q != '0);
	assign root = root_q;
endmodule
`default_nettype wire

// ===== design/capacity_seed_assignment.sv =====
// Capacity seed assignment: ring of vehicle cells plus a serial distance unit.
// Depends on csa_pkg, csa_if, csa_cell, csa_isqrt, assert_macros.svh.
// Load item: writes the seed and full capacity into its vehicle cell, no result.
//   Assign item: one distance for the depot and two per vehicle that can take the demand,
//   each a registered square step and then the shared bit-serial root, plus a ring step
//   per position; a new item is accepted only after the result has been taken.
// Reset clears capacities, config registers (vehicle count to 1) and control.
`default_nettype none
`include "assert_macros.svh"
module capacity_seed_assignment (
	input  wire logic clk,
	input  wire logic arst_n,
	csa_in_if.sink   in_ch,
	csa_out_if.source out_ch,
	input  wire logic cfg_we,
	input  wire logic [csa_pkg::CfgIdxW-1:0] cfg_idx,
	input  wire logic [csa_pkg::CfgDataW-1:0] cfg_data
);
	import csa_pkg::*;

	logic signed [CoordW-1:0] depot_x_q, depot_y_q;
	logic [CapW-1:0] vcap_q;
	logic [4:0] vcount_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depot_x_q <= '0;
			depot_y_q <= '0;
			vcap_q <= '0;
			vcount_q <= 5'd1;
		end else if (cfg_we) begin
			case (cfg_idx)
				CfgDepotX: depot_x_q <= cfg_data;
				CfgDepotY: depot_y_q <= cfg_data;
				CfgCap: vcap_q <= cfg_data;
				CfgCount: vcount_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	state_t st_q, st_d;
	logic signed [CoordW-1:0] cx_q, cy_q;
	logic [CapW-1:0] dem_q;
	logic [1:0] phase_q;	// 0 depot-customer, 1 customer-seed, 2 depot-seed
	logic [CntW-1:0] pos_q;	// ring rotations done
	logic signed [CostW-1:0] d0c_q, acc_q, best_cost_q;
	logic found_q;
	logic [VidxW-1:0] best_q;
	logic [CapW-1:0] best_cap_q;
	logic out_valid_q;
	logic [CntW-1:0] count_eff;

	assign count_eff = (vcount_q > 5'(MaxVehicles)) ? CntW'(MaxVehicles) : CntW'(vcount_q);

	// ring of cells; cell 0 is the head the sequencer reads
	cell_data_t cells [MaxVehicles];
	cell_ctrl_t ctrl;

	for (genvar g = 0; g < MaxVehicles; g++) begin : g_cell
		csa_cell u_cell (
			.clk(clk), .arst_n(arst_n), .ctrl(ctrl),
			.prev(cells[(g + 1) % MaxVehicles]),
			.new_x(in_ch.pos_x), .new_y(in_ch.pos_y), .new_cap(vcap_q),
			.sub_amt(dem_q), .home(VidxW'(g)), .cur(cells[g])
		);
	end

	cell_data_t head;
	assign head = cells[0];
	logic head_active, head_ok;
	assign head_active = head.idx < VidxW'(count_eff - 1'b1) || head.idx == VidxW'(count_eff - 1'b1);
	// unloaded cells hold capacity zero, so they qualify only for zero demand
	assign head_ok = (count_eff != '0) && head_active && head.cap >= dem_q;

	// distance operands for the current phase
	logic signed [CoordW:0] dx, dy;
	logic [CoordW:0] ux, uy;
	logic [2*CoordW+1:0] sq_s1;
	logic [2*CoordW+1:0] pxx_s1, pyy_s1;
	logic sq_go;
	logic [RadW-1:0] rad;
	logic root_busy;
	logic [DistW-1:0] root;

	always_comb begin
		case (phase_q)
			2'd0: begin
				dx = 17'(depot_x_q) - 17'(cx_q);
				dy = 17'(depot_y_q) - 17'(cy_q);
			end
			2'd1: begin
				dx = 17'(cx_q) - 17'(head.sx);
				dy = 17'(cy_q) - 17'(head.sy);
			end
			default: begin
				dx = 17'(depot_x_q) - 17'(head.sx);
				dy = 17'(depot_y_q) - 17'(head.sy);
			end
		endcase
		ux = dx[CoordW] ? 17'(-dx) : 17'(dx);
		uy = dy[CoordW] ? 17'(-dy) : 17'(dy);
	end

	// square both differences, then add and scale by 2^16
	always_ff @(posedge clk) begin
		pxx_s1 <= 34'(ux) * 34'(ux);
		pyy_s1 <= 34'(uy) * 34'(uy);
	end
	assign sq_s1 = pxx_s1 + pyy_s1;
	assign rad = {sq_s1[RadW-17:0], 16'b0};

	csa_isqrt u_root (
		.clk(clk), .arst_n(arst_n), .start(sq_go), .rad(rad),
		.busy(root_busy), .root(root)
	);

	logic sq_wait_q;	// waits for the registered squares to settle
	logic root_started_q;
	logic signed [CostW-1:0] rootc;
	logic signed [CostW-1:0] cost;
	assign rootc = CostW'(root);
	assign cost = acc_q - rootc;

	logic in_take, out_take;
	assign in_ch.ready = (st_q == ST_IDLE);
	assign in_take = in_ch.valid && in_ch.ready;
	assign out_take = out_ch.valid && out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= ST_IDLE;
		else st_q <= st_d;
	end

	logic root_done;
	assign root_done = root_started_q && !root_busy;

	always_comb begin
		st_d = st_q;
		sq_go = 1'b0;
		ctrl = '0;
		ctrl.load_idx = in_ch.seed_index;
		ctrl.sub_idx = best_q;
		case (st_q)
			ST_IDLE: begin
				if (in_take) begin
					if (in_ch.mode) ctrl.load = 1'b1;
					else st_d = ST_SQ;
				end
			end
			ST_SQ: begin
				// skip vehicles that cannot take the demand
				if (phase_q != 2'd0 && !head_ok) st_d = ST_NEXT;
				else if (sq_wait_q) begin
					sq_go = 1'b1;
					st_d = ST_ROOT;
				end
			end
			ST_ROOT: begin
				if (root_done) begin
					if (phase_q == 2'd2) st_d = ST_NEXT;
					else st_d = ST_SQ;
				end
			end
			ST_NEXT: begin
				ctrl.shift = 1'b1;
				if (pos_q == CntW'(MaxVehicles - 1)) st_d = ST_DONE;
				else st_d = ST_SQ;
			end
			ST_DONE: begin
				ctrl.sub = found_q;
				st_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_take) st_d = ST_IDLE;
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			pos_q <= '0;
			found_q <= 1'b0;
			sq_wait_q <= 1'b0;
			root_started_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			sq_wait_q <= (st_q == ST_SQ) && !sq_wait_q && !(phase_q != 2'd0 && !head_ok);
			if (sq_go) root_started_q <= 1'b1;
			else if (root_done) root_started_q <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					phase_q <= 2'd0;
					pos_q <= '0;
					found_q <= 1'b0;
				end
				ST_ROOT: begin
					if (root_done) phase_q <= (phase_q == 2'd2) ? 2'd2 : phase_q + 2'd1;
					if (root_done && phase_q == 2'd2 &&
							(!found_q || cost < best_cost_q)) begin
						found_q <= 1'b1;
					end
				end
				ST_NEXT: begin
					phase_q <= 2'd1;
					pos_q <= pos_q + 1'b1;
				end
				default: ;
			endcase
			if (st_q == ST_DONE) out_valid_q <= 1'b1;
			else if (out_take) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			cx_q <= in_ch.pos_x;
			cy_q <= in_ch.pos_y;
			dem_q <= in_ch.demand;
		end
		if (st_q == ST_ROOT && root_done) begin
			case (phase_q)
				2'd0: d0c_q <= rootc;
				2'd1: acc_q <= d0c_q + rootc;
				default: begin
					// the ring visits vehicles in index order: a strict compare
					// keeps the lower index on a tie
					if (!found_q || cost < best_cost_q) begin
						best_cost_q <= cost;
						best_q <= head.idx;
						best_cap_q <= head.cap - dem_q;
					end
				end
			endcase
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.assigned = found_q;
	assign out_ch.vehicle = found_q ? best_q : '0;
	assign out_ch.capacity_left = found_q ? best_cap_q : '0;

	`ASSERT_IMPLIES(a_no_take_busy, clk, arst_n, st_q != ST_IDLE, !in_ch.ready)
	`ASSERT_IMPLIES(a_out_in_state, clk, arst_n, out_valid_q, st_q == ST_OUT)
	`ASSERT_NEXT(a_go_root, clk, arst_n, sq_go, root_busy)
endmodule
`default_nettype wire
